FILE: hw/rtl/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, codes and helpers for the JSON string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;    // log2(QDEPTH)
  localparam int QCW    = 3;    // holds 0..QDEPTH

  // body kind of one command word
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] KIND_ESC  = 2'd2;
  localparam logic [1:0] KIND_UHEX = 2'd3;

  // what follows the body
  localparam logic [1:0] TAIL_NONE  = 2'd0;
  localparam logic [1:0] TAIL_CLOSE = 2'd1;
  localparam logic [1:0] TAIL_ERR   = 2'd2;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;

  typedef struct packed {
    logic        open_q;
    logic [1:0]  kind;
    logic [1:0]  tail;
    logic [15:0] data;   // byte or escape letter in [7:0], code point for UHEX
  } jse_cmd_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = 8'h30 + {4'd0, n};
    else           c = 8'h57 + {4'd0, n};   // 'a' - 10
    return c;
  endfunction

  function automatic logic [7:0] escape_letter(input logic [7:0] b);
    logic [7:0] c;
    unique case (b)
      8'h22:   c = 8'h22;
      8'h5C:   c = 8'h5C;
      8'h08:   c = 8'h62;   // b
      8'h0C:   c = 8'h66;   // f
      8'h0A:   c = 8'h6E;   // n
      8'h0D:   c = 8'h72;   // r
      8'h09:   c = 8'h74;   // t
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/jse_front.sv
// ----------------------------------------------------------------------------
// jse_front
// Accepts input bytes, tracks UTF-8 gathering state and issues command words.
// ----------------------------------------------------------------------------
module jse_front import jse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [0:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_is_first,
  input  logic       in_is_last,
  input  logic       in_is_empty,
  input  logic       q_full,
  output logic       q_push,
  output jse_cmd_t   q_cmd
);

  logic        ucs2_r;
  logic [1:0]  pend_r, pend_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic        drop_r, drop_nxt;
  logic        accept;
  jse_cmd_t    cmd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic        erred;
    logic [7:0]  letter;
    erred    = 1'b0;
    letter   = escape_letter(in_byte);
    cmd      = '{open_q: 1'b0, kind: KIND_NONE, tail: TAIL_NONE, data: 16'd0};
    pend_nxt = in_is_first ? 2'd0  : pend_r;
    acc_nxt  = in_is_first ? 16'd0 : acc_r;
    drop_nxt = in_is_first ? 1'b0  : drop_r;
    if (in_is_empty) begin
      pend_nxt   = 2'd0;
      acc_nxt    = 16'd0;
      drop_nxt   = 1'b0;
      cmd.open_q = 1'b1;
      cmd.tail   = TAIL_CLOSE;
    end else begin
      cmd.open_q = in_is_first;
      if (drop_nxt) begin
        if (in_is_last) drop_nxt = 1'b0;
      end else begin
        if (pend_nxt != 2'd0) begin
          acc_nxt  = {acc_nxt[9:0], in_byte[5:0]};
          pend_nxt = pend_nxt - 2'd1;
          if (pend_nxt == 2'd0) begin
            cmd.kind = KIND_UHEX;
            cmd.data = acc_nxt;
          end
        end else if (letter != 8'h00) begin
          cmd.kind = KIND_ESC;
          cmd.data = {8'd0, letter};
        end else if (ucs2_r && in_byte[7]) begin
          if (in_byte[7:4] == 4'hE) begin
            acc_nxt  = {12'd0, in_byte[3:0]};
            pend_nxt = 2'd2;
          end else if (in_byte[7:5] == 3'b110) begin
            acc_nxt  = {11'd0, in_byte[4:0]};
            pend_nxt = 2'd1;
          end else begin
            erred    = 1'b1;
            cmd.tail = TAIL_ERR;
            pend_nxt = 2'd0;
            acc_nxt  = 16'd0;
            drop_nxt = !in_is_last;
          end
        end else begin
          cmd.kind = KIND_BYTE;
          cmd.data = {8'd0, in_byte};
        end
        if (in_is_last && !erred) begin
          if (pend_nxt != 2'd0) begin
            // sequence cut off by the end of the string
            cmd.tail = TAIL_ERR;
            pend_nxt = 2'd0;
            acc_nxt  = 16'd0;
            drop_nxt = 1'b0;
          end else begin
            cmd.tail = TAIL_CLOSE;
          end
        end
      end
    end
  end

  assign q_cmd  = cmd;
  assign q_push = accept && (cmd.open_q || cmd.kind != KIND_NONE || cmd.tail != TAIL_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ucs2_r <= 1'b0;
      pend_r <= 2'd0;
      acc_r  <= 16'd0;
      drop_r <= 1'b0;
    end else begin
      if (cfg_we) ucs2_r <= cfg_wdata[0];
      if (accept) begin
        pend_r <= pend_nxt;
        acc_r  <= acc_nxt;
        drop_r <= drop_nxt;
      end
    end
  end

endmodule

FILE: hw/rtl/jse_fifo.sv
// ----------------------------------------------------------------------------
// jse_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module jse_fifo import jse_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  jse_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     avail,
  output jse_cmd_t head
);

  jse_cmd_t         mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCW'(QDEPTH));
  assign avail = (cnt_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/jse_back.sv
// ----------------------------------------------------------------------------
// jse_back
// Expands command words into escaped output bytes, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module jse_back import jse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_avail,
  input  jse_cmd_t   q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_string_done,
  output logic       out_bad_utf8
);

  localparam logic [1:0] PH_OPEN = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_TAIL = 2'd2;

  jse_cmd_t   cur_r;
  logic       busy_r, busy_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [2:0] idx_r, idx_nxt;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r, out_done_r, out_bad_r;

  logic       out_can, fire, is_last, load;
  logic [7:0] cur_byte;
  logic       cur_done, cur_bad;
  logic [2:0] body_len;

  assign out_can = !out_valid_r || out_ready;
  assign fire    = busy_r && out_can;

  always_comb begin
    unique case (cur_r.kind)
      KIND_BYTE: body_len = 3'd1;
      KIND_ESC:  body_len = 3'd2;
      KIND_UHEX: body_len = 3'd6;
      default:   body_len = 3'd0;
    endcase
  end

  // current byte
  always_comb begin
    cur_byte = CH_QUOTE;
    cur_done = 1'b0;
    cur_bad  = 1'b0;
    unique case (ph_r)
      PH_OPEN: cur_byte = CH_QUOTE;
      PH_BODY: begin
        if (cur_r.kind == KIND_BYTE) begin
          cur_byte = cur_r.data[7:0];
        end else if (idx_r == 3'd0) begin
          cur_byte = CH_BSLASH;
        end else if (cur_r.kind == KIND_ESC) begin
          cur_byte = cur_r.data[7:0];
        end else begin
          unique case (idx_r)
            3'd1:    cur_byte = CH_U;
            3'd2:    cur_byte = hex_char(cur_r.data[15:12]);
            3'd3:    cur_byte = hex_char(cur_r.data[11:8]);
            3'd4:    cur_byte = hex_char(cur_r.data[7:4]);
            default: cur_byte = hex_char(cur_r.data[3:0]);
          endcase
        end
      end
      default: begin
        cur_done = 1'b1;
        if (cur_r.tail == TAIL_ERR) begin
          cur_byte = 8'h00;
          cur_bad  = 1'b1;
        end
      end
    endcase
  end

  // step to the next emission of the same word
  always_comb begin
    ph_nxt  = PH_TAIL;
    idx_nxt = 3'd0;
    is_last = 1'b0;
    priority case (ph_r)
      PH_OPEN: begin
        if (cur_r.kind != KIND_NONE)      ph_nxt = PH_BODY;
        else if (cur_r.tail != TAIL_NONE) ph_nxt = PH_TAIL;
        else                              is_last = 1'b1;
      end
      PH_BODY: begin
        if (idx_r + 3'd1 < body_len) begin
          ph_nxt  = PH_BODY;
          idx_nxt = idx_r + 3'd1;
        end else if (cur_r.tail == TAIL_NONE) begin
          is_last = 1'b1;
        end
      end
      default: is_last = 1'b1;
    endcase
  end

  assign load  = q_avail && (!busy_r || (fire && is_last));
  assign q_pop = load;

  always_comb begin
    busy_nxt = busy_r;
    if (load)                 busy_nxt = 1'b1;
    else if (fire && is_last) busy_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_head;
      idx_r <= 3'd0;
      if (q_head.open_q)                ph_r <= PH_OPEN;
      else if (q_head.kind != KIND_NONE) ph_r <= PH_BODY;
      else                               ph_r <= PH_TAIL;
    end else if (fire) begin
      ph_r  <= ph_nxt;
      idx_r <= idx_nxt;
    end
    if (fire) begin
      out_byte_r <= cur_byte;
      out_last_r <= is_last;
      out_done_r <= cur_done;
      out_bad_r  <= cur_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (fire)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_run_last    = out_last_r;
  assign out_string_done = out_done_r;
  assign out_bad_utf8    = out_bad_r;

  // error words carry a zero byte and end the string
  a_bad_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_done_r && out_byte_r == 8'h00)
    else $error("error word without done or with nonzero byte");

  // closing quote and error are always the final word of their run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_last_r)
    else $error("string done not on run end");

  a_tail_kind: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && ph_r == PH_TAIL |-> cur_r.tail != TAIL_NONE)
    else $error("tail phase without tail");

  a_body_kind: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && ph_r == PH_BODY |-> cur_r.kind != KIND_NONE && idx_r < body_len)
    else $error("body index out of range");

endmodule

FILE: hw/rtl/json_string_escaper_top.sv
// A word's command passes the command queue, the expander's word register and the
// output register. Throughput: one input word per cycle while each yields at most
// one result and the output is not stalled; a word with n results (n up to 7) holds
// the output expander until its last result is sent, and a 4-entry command queue
// lets the input side keep accepting meanwhile. Reset (rst_n low, synchronous)
// clears UTF-8 gather state, queue and output; force_ucs2 resets to 0.
// ----------------------------------------------------------------------------
// json_string_escaper_top
// JSON string escaper: quotes, backslash escapes and optional \uXXXX output.
// ----------------------------------------------------------------------------
module json_string_escaper_top import jse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [0:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_is_first,
  input  logic       in_is_last,
  input  logic       in_is_empty,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_string_done,
  output logic       out_bad_utf8
);

  logic     q_full, q_push, q_pop, q_avail;
  jse_cmd_t q_cmd, q_head;

  jse_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .in_is_first (in_is_first),
    .in_is_last  (in_is_last),
    .in_is_empty (in_is_empty),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd)
  );

  jse_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  jse_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_avail         (q_avail),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_string_done (out_string_done),
    .out_bad_utf8    (out_bad_utf8)
  );

endmodule

FILE: tb/sv/tb_json_string_escaper_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_string_escaper_top
// Self-checking bench for the JSON string escaper. Strings go in as byte words
// with first/last marks. A software predictor builds the JSON text expected
// for each accepted word. The output channel is compared word by word. Covers
// both force_ucs2 settings, UTF-8 gathering, errors, drops and back-pressure.
// ----------------------------------------------------------------------------
module tb_json_string_escaper_top import jse_pkg::*;;

  localparam logic [7:0] ASC_BS  = 8'h08;
  localparam logic [7:0] ASC_TAB = 8'h09;
  localparam logic [7:0] ASC_LF  = 8'h0A;
  localparam logic [7:0] ASC_FF  = 8'h0C;
  localparam logic [7:0] ASC_CR  = 8'h0D;
  localparam logic [7:0] ASC_NUL = 8'h00;
  localparam logic [7:0] ASC_DEL = 8'h7F;
  localparam logic [7:0] ASC_SP  = 8'h20;
  localparam logic [7:0] ASC_TLD = 8'h7E;

  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 120;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       empty;
  } raw_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       done;
    logic       bad;
  } text_word_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_is_first = 1'b0;
  logic       in_is_last = 1'b0;
  logic       in_is_empty = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_string_done;
  logic       out_bad_utf8;

  raw_word_t  raw_words_q[$];
  text_word_t json_text_q[$];
  text_word_t run_words[$];
  logic [7:0] str_bytes[$];

  // predictor state
  logic        ucs2_mode = 1'b0;
  logic [1:0]  gather_left = 2'd0;
  logic [15:0] code_point = 16'd0;
  logic        skip_rest = 1'b0;

  int words_queued = 0;
  int bytes_taken = 0;
  int strings_taken = 0;
  int words_seen = 0;
  int utf8_errors = 0;
  int cfg_writes = 0;
  int fail_count = 0;

  json_string_escaper_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_is_first    (in_is_first),
    .in_is_last     (in_is_last),
    .in_is_empty    (in_is_empty),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_done(out_string_done),
    .out_bad_utf8   (out_bad_utf8)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [7:0] json_escape_of(input logic [7:0] b);
    case (b)
      CH_QUOTE:  return CH_QUOTE;
      CH_BSLASH: return CH_BSLASH;
      ASC_BS:    return "b";
      ASC_FF:    return "f";
      ASC_LF:    return "n";
      ASC_CR:    return "r";
      ASC_TAB:   return "t";
      default:   return ASC_NUL;
    endcase
  endfunction

  function automatic logic [7:0] hex_ascii(input logic [3:0] n);
    if (n > 4'd9) return 8'h60 + {4'd0, n - 4'd9};
    return {4'h3, n};
  endfunction

  function automatic void emit(input logic [7:0] ch, input logic done, input logic bad);
    text_word_t w;
    w.ch = ch;
    w.run_last = 1'b0;
    w.done = done;
    w.bad = bad;
    run_words.insert(run_words.size(), w);
  endfunction

  function automatic void flag_bad(input logic at_last);
    emit(ASC_NUL, 1'b1, 1'b1);
    gather_left = 2'd0;
    code_point = 16'd0;
    skip_rest = !at_last;
  endfunction

  // Work out the JSON text caused by one accepted word and queue it.
  function automatic void escape_word(input raw_word_t w);
    logic erred;
    text_word_t t;
    erred = 1'b0;
    run_words.delete();
    if (w.empty) begin
      gather_left = 2'd0;
      code_point = 16'd0;
      skip_rest = 1'b0;
      emit(CH_QUOTE, 1'b0, 1'b0);
      emit(CH_QUOTE, 1'b1, 1'b0);
    end else begin
      if (w.first) begin
        gather_left = 2'd0;
        code_point = 16'd0;
        skip_rest = 1'b0;
        emit(CH_QUOTE, 1'b0, 1'b0);
      end
      if (skip_rest) begin
        if (w.last) skip_rest = 1'b0;
      end else begin
        if (gather_left != 2'd0) begin
          // continuation: low six bits taken unchecked
          code_point = {code_point[9:0], w.data[5:0]};
          gather_left = gather_left - 2'd1;
          if (gather_left == 2'd0) begin
            emit(CH_BSLASH, 1'b0, 1'b0);
            emit(CH_U, 1'b0, 1'b0);
            emit(hex_ascii(code_point[15:12]), 1'b0, 1'b0);
            emit(hex_ascii(code_point[11:8]), 1'b0, 1'b0);
            emit(hex_ascii(code_point[7:4]), 1'b0, 1'b0);
            emit(hex_ascii(code_point[3:0]), 1'b0, 1'b0);
          end
        end else if (json_escape_of(w.data) != ASC_NUL) begin
          emit(CH_BSLASH, 1'b0, 1'b0);
          emit(json_escape_of(w.data), 1'b0, 1'b0);
        end else if (ucs2_mode && w.data[7]) begin
          if (w.data[7:4] == 4'hE) begin
            code_point = {12'd0, w.data[3:0]};
            gather_left = 2'd2;
          end else if (w.data[7:5] == 3'b110) begin
            code_point = {11'd0, w.data[4:0]};
            gather_left = 2'd1;
          end else begin
            flag_bad(w.last);
            erred = 1'b1;
          end
        end else begin
          emit(w.data, 1'b0, 1'b0);
        end
        if (w.last && !erred) begin
          if (gather_left != 2'd0) flag_bad(1'b1);
          else emit(CH_QUOTE, 1'b1, 1'b0);
        end
      end
    end
    for (int i = 0; i < run_words.size(); i++) begin
      t = run_words[i];
      t.run_last = (i == run_words.size() - 1);
      json_text_q.insert(json_text_q.size(), t);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic void push_word(input logic [7:0] data, input logic first,
                                    input logic last, input logic empty);
    raw_word_t w;
    w.data = data;
    w.first = first;
    w.last = last;
    w.empty = empty;
    raw_words_q.insert(raw_words_q.size(), w);
    words_queued++;
  endfunction

  function automatic void add_str_byte(input logic [7:0] b);
    str_bytes.insert(str_bytes.size(), b);
  endfunction

  function automatic logic [7:0] pick_escapable();
    case ($urandom_range(0, 6))
      0:       return CH_QUOTE;
      1:       return CH_BSLASH;
      2:       return ASC_BS;
      3:       return ASC_FF;
      4:       return ASC_LF;
      5:       return ASC_CR;
      default: return ASC_TAB;
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 4) == 0) return 8'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  // Mostly well-formed strings with random content; some noise and cut-offs.
  function automatic void add_random_string();
    int shape;
    int parts;
    int pick;
    logic skip_first;
    logic skip_last;
    shape = $urandom_range(0, 99);
    if (shape < 8) begin
      push_word(8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
      return;
    end
    str_bytes.delete();
    parts = $urandom_range(1, 6);
    for (int k = 0; k < parts; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        add_str_byte(8'($urandom_range(ASC_SP, ASC_TLD)));
      end else if (pick < 50) begin
        add_str_byte(pick_escapable());
      end else if (pick < 65) begin
        add_str_byte({3'b110, 5'($urandom)});
        add_str_byte(cont_byte());
      end else if (pick < 80) begin
        add_str_byte({4'hE, 4'($urandom)});
        add_str_byte(cont_byte());
        add_str_byte(cont_byte());
      end else if (pick < 92) begin
        add_str_byte(8'($urandom));
      end else begin
        // lead with a short tail: truncates at the end, else swallows what follows
        add_str_byte({4'hE, 4'($urandom)});
        if ($urandom_range(0, 1) == 1) add_str_byte(cont_byte());
      end
    end
    skip_first = ($urandom_range(0, 99) < 4);
    skip_last = ($urandom_range(0, 99) < 5);
    for (int k = 0; k < str_bytes.size(); k++)
      push_word(str_bytes[k], (k == 0) && !skip_first,
                (k == str_bytes.size() - 1) && !skip_last, 1'b0);
  endfunction

  task automatic wait_idle();
    while (bytes_taken != words_queued) @(posedge clk);
    while (json_text_q.size() != 0) @(posedge clk);
    // words that make no text may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_ucs2(input logic v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ucs2_mode = v;
    cfg_writes++;
  endtask

  initial begin
    logic [3:0] ph_mode;
    ph_mode = 4'b1101;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // plain mode after reset: escapes, pass-through, empty, missing first mark
    push_word(8'hFF, 1'b1, 1'b1, 1'b1);
    push_word(CH_QUOTE, 1'b1, 1'b0, 1'b0);
    push_word(CH_BSLASH, 1'b0, 1'b0, 1'b0);
    push_word(ASC_BS, 1'b0, 1'b0, 1'b0);
    push_word(ASC_FF, 1'b0, 1'b0, 1'b0);
    push_word(ASC_LF, 1'b0, 1'b0, 1'b0);
    push_word(ASC_CR, 1'b0, 1'b0, 1'b0);
    push_word(ASC_TAB, 1'b0, 1'b0, 1'b0);
    push_word(ASC_NUL, 1'b0, 1'b0, 1'b0);
    push_word(8'hFF, 1'b0, 1'b0, 1'b0);
    push_word(ASC_DEL, 1'b0, 1'b0, 1'b0);
    push_word(8'hC3, 1'b0, 1'b1, 1'b0);
    push_word("A", 1'b0, 1'b0, 1'b0);
    wait_idle();

    write_ucs2(1'b1);
    push_word(8'hC3, 1'b1, 1'b0, 1'b0);   // two-byte sequence
    push_word(8'hA9, 1'b0, 1'b1, 1'b0);
    push_word(8'hE2, 1'b1, 1'b0, 1'b0);   // three-byte, last mark on final byte
    push_word(8'h82, 1'b0, 1'b0, 1'b0);
    push_word(8'hAC, 1'b0, 1'b1, 1'b0);
    push_word(8'hF0, 1'b1, 1'b1, 1'b0);   // 4-byte lead is illegal
    push_word("a", 1'b1, 1'b0, 1'b0);     // illegal lead mid-string, rest dropped
    push_word(8'hBF, 1'b0, 1'b0, 1'b0);
    push_word("b", 1'b0, 1'b0, 1'b0);
    push_word("c", 1'b0, 1'b1, 1'b0);
    push_word(8'hE2, 1'b1, 1'b0, 1'b0);   // cut off by last mark
    push_word(8'h82, 1'b0, 1'b1, 1'b0);
    push_word(8'hC3, 1'b1, 1'b0, 1'b0);   // abandoned by a new first mark
    push_word("d", 1'b1, 1'b1, 1'b0);
    push_word(8'hC3, 1'b1, 1'b0, 1'b0);   // left open across a mode change
    wait_idle();
    write_ucs2(1'b0);
    push_word(8'h80, 1'b0, 1'b1, 1'b0);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      write_ucs2(ph_mode[ph]);
      while (words_queued < 29 + 75 * (ph + 1)) add_random_string();
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d words in %0d strings, %0d text words, %0d UTF-8 errors,",
             bytes_taken, strings_taken, words_seen, utf8_errors);
    $display("with %0d force_ucs2 writes and random stalls on both sides.", cfg_writes);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : drive_p
    raw_word_t cur_word;
    int burst_left;
    int gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 4;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        escape_word(cur_word);
        bytes_taken++;
        if (cur_word.first || cur_word.empty) strings_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (raw_words_q.size() > 0) begin
          cur_word = raw_words_q.pop_front();
          in_byte <= cur_word.data;
          in_is_first <= cur_word.first;
          in_is_last <= cur_word.last;
          in_is_empty <= cur_word.empty;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
              0, 1, 2, 3: gap_left = 0;
              9:          gap_left = $urandom_range(8, 16);
              default:    gap_left = $urandom_range(1, 5);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin : rx_ready_p
    rx_mode_t stall_mode;
    int mode_left;
    int hold_left;
    int rx_count;
    int next_hold_at;
    int rx_tick;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_mode = RX_FREE;
      mode_left = 0;
      hold_left = 0;
      rx_count = 0;
      next_hold_at = 200;
      rx_tick = 0;
    end else begin
      rx_tick++;
      if (out_valid && out_ready) rx_count++;
      if (hold_left == 0 && rx_count >= next_hold_at) begin
        hold_left = LONG_HOLD;
        next_hold_at += 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (stall_mode)
          RX_FREE:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom);
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= (rx_tick % 3 != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : check_p
    text_word_t want;
    if (rst_n && out_valid && out_ready) begin
      words_seen++;
      if (out_bad_utf8 === 1'b1) utf8_errors++;
      if (json_text_q.size() == 0) begin
        $error("unexpected text word: out_byte %h", out_byte);
        fail_count++;
      end else begin
        want = json_text_q.pop_front();
        if (out_byte !== want.ch) begin
          $error("out_byte: expected %h, got %h", want.ch, out_byte);
          fail_count++;
        end
        if (out_run_last !== want.run_last) begin
          $error("out_run_last: expected %b, got %b", want.run_last, out_run_last);
          fail_count++;
        end
        if (out_string_done !== want.done) begin
          $error("out_string_done: expected %b, got %b", want.done, out_string_done);
          fail_count++;
        end
        if (out_bad_utf8 !== want.bad) begin
          $error("out_bad_utf8: expected %b, got %b", want.bad, out_bad_utf8);
          fail_count++;
        end
      end
    end
  end

endmodule
